// File: sv/srag_pkg.sv
`default_nettype none

package srag_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 4096;
	localparam int unsigned LEVEL_BITS_DEF = 24;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned GATE_W  = 16;
	localparam int unsigned OPLEV_W = 16;
	localparam int unsigned RANGE_W = 14;
	localparam int unsigned BAND_W  = 13;
	localparam int unsigned STEP_W  = 11;
	localparam int unsigned WLEN_W  = 13;
	localparam int unsigned GAIN_W  = 15;
	localparam int unsigned WLEV_W  = 17;

	localparam logic signed [GATE_W-1:0]  GATE_RST  = -16'sd12800;
	localparam logic signed [OPLEV_W-1:0] OPLEV_RST = -16'sd4608;
	localparam logic [RANGE_W-1:0]        RANGE_RST = 14'd2560;
	localparam logic [BAND_W-1:0]         BAND_RST  = 13'd768;
	localparam logic [STEP_W-1:0]         STEP_RST  = 11'd16;
	localparam logic [WLEN_W-1:0]         WLEN_RST  = 13'd400;

	// 10*log10(2) * 256 * 2^16
	localparam logic [25:0] DB_PER_LOG2 = 26'd50504453;
	localparam logic signed [WLEV_W-1:0] WLEV_FLOOR = -17'sd46080;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GATE  = 3'd0,
		REG_OPLEV = 3'd1,
		REG_RANGE = 3'd2,
		REG_BAND  = 3'd3,
		REG_STEP  = 3'd4,
		REG_WLEN  = 3'd5
	} srag_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG_LVL,
		ST_DB_MUL,
		ST_DB_RND,
		ST_GATE,
		ST_RD,
		ST_LS_GO,
		ST_LS_WAIT,
		ST_LN_GO,
		ST_LN_WAIT,
		ST_TARGET,
		ST_SLEW,
		ST_OUT
	} srag_state_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_LOAD,
		LG_SQR
	} srag_lph_t;

	// Q16 log2, elaboration use only
	function automatic logic [63:0] log2_q16_fn(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] m;
		logic [63:0] p;
		logic [5:0]  e;
		logic [15:0] f;
		x = (v == 64'd0) ? 64'd1 : v;
		e = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (x[i]) e = 6'(i);
		end
		m = (x << (6'd63 - e)) >> 32;
		f = 16'd0;
		for (int i = 0; i < 16; i++) begin
			p = m * m;
			m = p >> 31;
			f = {f[14:0], m[32]};
			if (m[32]) m = m >> 1;
		end
		return {42'd0, e, f};
	endfunction

endpackage

`default_nettype wire

// File: sv/srag_log2.sv
`default_nettype none

module srag_log2 #(
	parameter int unsigned LW = 60
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [LW-1:0]              operand,
	output logic                            done,
	output logic [$clog2(LW)+16-1:0]        result
);

	localparam int unsigned EW = $clog2(LW);
	localparam int unsigned NS = $clog2(LW);
	localparam logic [EW:0] LW_V = (EW+1)'(LW);

	srag_pkg::srag_lph_t ph_q, ph_d;
	logic [3:0]    cnt_q;
	logic [LW-1:0] norm_q;
	logic [EW-1:0] e_q;
	logic [31:0]   m_q;
	logic [15:0]   frac_q;
	logic          done_q;

	logic          norm_en, load_en, sqr_en;
	logic [EW:0]   sh;
	logic          topz;
	logic [LW+31:0] ext;
	logic [63:0]   p;
	logic [32:0]   m2;

	assign sh   = (EW+1)'(1) << cnt_q;
	assign topz = ((norm_q >> (LW_V - sh)) == '0);
	assign ext  = {norm_q, 32'd0};
	assign p    = m_q * m_q;
	assign m2   = p[63:31];

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			srag_pkg::LG_IDLE: if (start) ph_d = srag_pkg::LG_NORM;
			srag_pkg::LG_NORM: if (cnt_q == 4'd0) ph_d = srag_pkg::LG_LOAD;
			srag_pkg::LG_LOAD: ph_d = srag_pkg::LG_SQR;
			srag_pkg::LG_SQR:  if (cnt_q == 4'd0) ph_d = srag_pkg::LG_IDLE;
			default:           ph_d = srag_pkg::LG_IDLE;
		endcase
	end

	always_comb begin
		norm_en = (ph_q == srag_pkg::LG_NORM);
		load_en = (ph_q == srag_pkg::LG_LOAD);
		sqr_en  = (ph_q == srag_pkg::LG_SQR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= srag_pkg::LG_IDLE;
			cnt_q  <= 4'd0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= ph_d;
			done_q <= sqr_en && (cnt_q == 4'd0);
			if (ph_q == srag_pkg::LG_IDLE && start) begin
				cnt_q <= 4'(NS - 1);
			end else if (norm_en || sqr_en) begin
				cnt_q <= cnt_q - 4'd1;
			end else if (load_en) begin
				cnt_q <= 4'd15;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == srag_pkg::LG_IDLE && start) begin
			norm_q <= (operand == '0) ? LW'(1) : operand;
			e_q    <= EW'(LW - 1);
		end else if (norm_en && topz) begin
			norm_q <= norm_q << sh;
			e_q    <= e_q - sh[EW-1:0];
		end
		if (load_en) begin
			m_q    <= ext[LW+31 -: 32];
			frac_q <= 16'd0;
		end else if (sqr_en) begin
			m_q    <= m2[32] ? m2[32:1] : m2[31:0];
			frac_q <= {frac_q[14:0], m2[32]};
		end
	end

	assign done   = done_q;
	assign result = {e_q, frac_q};

endmodule

`default_nettype wire

// File: sv/sliding_rms_agc_gain.sv
// Sliding-window RMS automatic gain control.
// Input channel (in_valid / in_stall, field level): one linear level per beat.
// Output channel (out_valid / out_stall): one result beat per input beat with
// gain, window_level, updated and gated, in input order.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the six
// registers; only taken while no item is in flight. Rewriting window_length
// with a new value clears the window sum, fill count, pointers and gain.
// Gated or filling items pass once through the shared log2 unit; items that
// recompute the gain pass through it three times (clog2 normalise steps
// plus 16 squaring steps each).
// One item is worked on at a time; the next beat is accepted once the
// result sits in the output register, even while the receiver stalls it.
// Window squares live in a single-port-write, registered-read RAM.
// Reset: registers return to defaults, window empty, gain zero; the RAM is
// not cleared, entries are only read after being written.
`default_nettype none

module sliding_rms_agc_gain #(
	parameter int unsigned MAX_WINDOW = srag_pkg::MAX_WINDOW_DEF,
	parameter int unsigned LEVEL_BITS = srag_pkg::LEVEL_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [LEVEL_BITS-1:0]                  level,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [srag_pkg::GAIN_W-1:0]          gain,
	output logic signed [srag_pkg::WLEV_W-1:0]          window_level,
	output logic                                        updated,
	output logic                                        gated,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [srag_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [srag_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int unsigned SQ_W  = 2 * LEVEL_BITS;
	localparam int unsigned PW    = $clog2(MAX_WINDOW);
	localparam int unsigned NW    = PW + 1;
	localparam int unsigned SUM_W = SQ_W + PW;
	localparam int unsigned LW    = SUM_W;
	localparam int unsigned RW    = $clog2(LW) + 16;
	localparam int unsigned DW    = RW + 3;
	localparam int unsigned PRW   = DW + 26;
	localparam int unsigned DBW   = DW - 4;
	localparam int unsigned GW    = srag_pkg::GAIN_W;
	localparam int unsigned WLW   = srag_pkg::WLEV_W;

	localparam logic [63:0]   FULL_SCALE = (64'd1 << (LEVEL_BITS - 1)) - 64'd1;
	localparam logic [RW-1:0] FS_LOG     = RW'(srag_pkg::log2_q16_fn(FULL_SCALE));
	localparam logic [NW-1:0] NMAX       = NW'(MAX_WINDOW);

	srag_pkg::srag_state_t state_q, state_d;

	logic signed [srag_pkg::GATE_W-1:0]  gate_q;
	logic signed [srag_pkg::OPLEV_W-1:0] oplev_q;
	logic [srag_pkg::RANGE_W-1:0]        range_q;
	logic [srag_pkg::BAND_W-1:0]         band_q;
	logic [srag_pkg::STEP_W-1:0]         step_q;
	logic [srag_pkg::WLEN_W-1:0]         wlen_q;

	logic [SUM_W-1:0]    sum_q;
	logic [NW-1:0]       fill_q;
	logic [PW-1:0]       wp_q, rp_q;
	logic signed [GW-1:0] gain_q;

	logic [SQ_W-1:0]     mem [MAX_WINDOW];
	logic [SQ_W-1:0]     rd_q;

	logic [SQ_W-1:0]     sq_q;
	logic [RW-1:0]       logs_q;
	logic signed [DW-1:0] d_q;
	logic                win_q;
	logic [PRW-1:0]      prod_q;
	logic                neg_q;
	logic signed [DBW-1:0] db_q;
	logic signed [GW-1:0] target_q;
	logic                upd_q, gated_q;
	logic signed [srag_pkg::WLEV_W-1:0] rep_q;

	logic                out_valid_q;
	logic signed [GW-1:0] gain_o_q;
	logic signed [srag_pkg::WLEV_W-1:0] wlev_o_q;
	logic                upd_o_q, gated_o_q;

	logic                accept, cfg_wr, out_load;
	logic                log_start, log_done;
	logic [LW-1:0]       log_opnd;
	logic [RW-1:0]       log_res;
	logic                mem_re, mem_we;

	logic [LEVEL_BITS-1:0] lvl_nz;
	logic [NW-1:0]       n_eff;
	logic [NW-1:0]       wp_nx, rp_nx;
	logic                full, gate_hit;
	logic [DW-1:0]       mag, magm;
	logic [PRW:0]        rnd;
	logic [DBW-1:0]      rmag;
	logic signed [DBW:0] ad;
	logic [srag_pkg::RANGE_W-1:0] tmag;
	logic signed [GW-1:0] target_c;
	logic signed [GW+1:0] diff, adiff, gain_nx;
	logic                slew_move;
	logic signed [srag_pkg::WLEV_W-1:0] rep_c;

	srag_log2 #(.LW(LW)) u_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (log_start),
		.operand (log_opnd),
		.done    (log_done),
		.result  (log_res)
	);

	assign accept   = in_valid && !in_stall;
	assign cfg_wr   = cfg_valid && cfg_ready;
	assign out_load = (state_q == srag_pkg::ST_OUT) && (!out_valid_q || !out_stall);
	assign lvl_nz   = (level == '0) ? LEVEL_BITS'(1) : level;

	always_comb begin
		if (wlen_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
			n_eff = NMAX;
		end else begin
			n_eff = NW'(wlen_q);
		end
	end

	assign wp_nx    = (NW'(wp_q) + NW'(1) >= n_eff) ? '0 : NW'(wp_q) + NW'(1);
	assign rp_nx    = (NW'(rp_q) + NW'(1) >= n_eff) ? '0 : NW'(rp_q) + NW'(1);
	assign full     = (fill_q >= n_eff);
	assign gate_hit = (db_q <= DBW'(gate_q));

	// dB conversion
	assign mag  = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
	assign magm = win_q ? mag : (mag << 1);
	assign rnd  = (PRW+1)'(prod_q) + (PRW+1)'(64'h8000_0000);
	assign rmag = DBW'(rnd[PRW:32]);

	// target from window level
	always_comb begin
		ad       = (db_q >= DBW'(oplev_q)) ? ((DBW+1)'(db_q) - (DBW+1)'(oplev_q))
		                                   : ((DBW+1)'(oplev_q) - (DBW+1)'(db_q));
		tmag     = (ad > (DBW+1)'(range_q)) ? range_q : ad[srag_pkg::RANGE_W-1:0];
		target_c = '0;
		if (db_q > DBW'(gate_q) && ad > (DBW+1)'(band_q)) begin
			target_c = (db_q >= DBW'(oplev_q)) ? -GW'(tmag) : GW'(tmag);
		end
	end

	assign diff      = (GW+2)'(gain_q) - (GW+2)'(target_q);
	assign adiff     = diff[GW+1] ? -diff : diff;
	assign slew_move = (adiff > (GW+2)'(step_q));
	assign gain_nx   = (gain_q > target_q) ? (GW+2)'(gain_q) - (GW+2)'(step_q)
	                                       : (GW+2)'(gain_q) + (GW+2)'(step_q);

	always_comb begin
		if (db_q < DBW'(srag_pkg::WLEV_FLOOR)) begin
			rep_c = srag_pkg::WLEV_FLOOR;
		end else if (db_q > DBW'(0)) begin
			rep_c = '0;
		end else begin
			rep_c = WLW'(db_q);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			srag_pkg::ST_IDLE:    if (accept) state_d = srag_pkg::ST_LOG_LVL;
			srag_pkg::ST_LOG_LVL: if (log_done) state_d = srag_pkg::ST_DB_MUL;
			srag_pkg::ST_DB_MUL:  state_d = srag_pkg::ST_DB_RND;
			srag_pkg::ST_DB_RND:  state_d = win_q ? srag_pkg::ST_TARGET : srag_pkg::ST_GATE;
			srag_pkg::ST_GATE: begin
				if (gate_hit || !full) state_d = srag_pkg::ST_OUT;
				else                   state_d = srag_pkg::ST_RD;
			end
			srag_pkg::ST_RD:      state_d = srag_pkg::ST_LS_GO;
			srag_pkg::ST_LS_GO:   state_d = srag_pkg::ST_LS_WAIT;
			srag_pkg::ST_LS_WAIT: if (log_done) state_d = srag_pkg::ST_LN_GO;
			srag_pkg::ST_LN_GO:   state_d = srag_pkg::ST_LN_WAIT;
			srag_pkg::ST_LN_WAIT: if (log_done) state_d = srag_pkg::ST_DB_MUL;
			srag_pkg::ST_TARGET:  state_d = srag_pkg::ST_SLEW;
			srag_pkg::ST_SLEW:    state_d = srag_pkg::ST_OUT;
			srag_pkg::ST_OUT:     if (out_load) state_d = srag_pkg::ST_IDLE;
			default:              state_d = srag_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != srag_pkg::ST_IDLE);
		cfg_ready = (state_q == srag_pkg::ST_IDLE);
		log_start = 1'b0;
		log_opnd  = LW'(lvl_nz);
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		case (state_q)
			srag_pkg::ST_IDLE:  log_start = accept;
			srag_pkg::ST_LS_GO: begin
				log_start = 1'b1;
				log_opnd  = sum_q;
			end
			srag_pkg::ST_LN_GO: begin
				log_start = 1'b1;
				log_opnd  = LW'(n_eff);
			end
			srag_pkg::ST_GATE: begin
				mem_we = !gate_hit && !full;
				mem_re = !gate_hit && full;
			end
			srag_pkg::ST_RD:    mem_we = 1'b1;
			default:            log_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srag_pkg::ST_IDLE;
			gate_q      <= srag_pkg::GATE_RST;
			oplev_q     <= srag_pkg::OPLEV_RST;
			range_q     <= srag_pkg::RANGE_RST;
			band_q      <= srag_pkg::BAND_RST;
			step_q      <= srag_pkg::STEP_RST;
			wlen_q      <= srag_pkg::WLEN_RST;
			sum_q       <= '0;
			fill_q      <= '0;
			wp_q        <= '0;
			rp_q        <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (srag_pkg::srag_reg_t'(cfg_index))
					srag_pkg::REG_GATE:  gate_q  <= cfg_data;
					srag_pkg::REG_OPLEV: oplev_q <= cfg_data;
					srag_pkg::REG_RANGE: range_q <= cfg_data[srag_pkg::RANGE_W-1:0];
					srag_pkg::REG_BAND:  band_q  <= cfg_data[srag_pkg::BAND_W-1:0];
					srag_pkg::REG_STEP:  step_q  <= cfg_data[srag_pkg::STEP_W-1:0];
					srag_pkg::REG_WLEN: begin
						if (cfg_data[srag_pkg::WLEN_W-1:0] != wlen_q) begin
							wlen_q <= cfg_data[srag_pkg::WLEN_W-1:0];
							sum_q  <= '0;
							fill_q <= '0;
							wp_q   <= '0;
							rp_q   <= '0;
							gain_q <= '0;
						end
					end
					default: ;
				endcase
			end
			if (state_q == srag_pkg::ST_GATE && !gate_hit && !full) begin
				sum_q  <= sum_q + SUM_W'(sq_q);
				fill_q <= fill_q + NW'(1);
				wp_q   <= wp_nx[PW-1:0];
			end
			if (state_q == srag_pkg::ST_RD) begin
				sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(sq_q);
				rp_q  <= rp_nx[PW-1:0];
				wp_q  <= wp_nx[PW-1:0];
			end
			if (state_q == srag_pkg::ST_SLEW && slew_move) begin
				gain_q <= GW'(gain_nx);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wp_q] <= sq_q;
		if (mem_re) rd_q <= mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_q    <= SQ_W'(lvl_nz) * SQ_W'(lvl_nz);
			upd_q   <= 1'b0;
			gated_q <= 1'b0;
			rep_q   <= '0;
		end
		if (state_q == srag_pkg::ST_LOG_LVL && log_done) begin
			d_q   <= $signed(DW'(log_res)) - $signed(DW'(FS_LOG));
			win_q <= 1'b0;
		end
		if (state_q == srag_pkg::ST_LS_WAIT && log_done) logs_q <= log_res;
		if (state_q == srag_pkg::ST_LN_WAIT && log_done) begin
			d_q   <= $signed(DW'(logs_q)) - $signed(DW'(log_res))
			         - $signed(DW'(FS_LOG) << 1);
			win_q <= 1'b1;
		end
		if (state_q == srag_pkg::ST_DB_MUL) begin
			prod_q <= PRW'(magm) * PRW'(srag_pkg::DB_PER_LOG2);
			neg_q  <= d_q[DW-1];
		end
		if (state_q == srag_pkg::ST_DB_RND) db_q <= neg_q ? -$signed(rmag) : $signed(rmag);
		if (state_q == srag_pkg::ST_GATE)   gated_q <= gate_hit;
		if (state_q == srag_pkg::ST_RD)     upd_q <= 1'b1;
		if (state_q == srag_pkg::ST_TARGET) target_q <= target_c;
		if (state_q == srag_pkg::ST_SLEW)   rep_q <= rep_c;
		if (out_load) begin
			gain_o_q  <= gain_q;
			wlev_o_q  <= rep_q;
			upd_o_q   <= upd_q;
			gated_o_q <= gated_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign gain         = gain_o_q;
	assign window_level = wlev_o_q;
	assign updated      = upd_o_q;
	assign gated        = gated_o_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= n_eff) else $error("fill count above window length");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(NW'(wp_q) < n_eff) && (NW'(rp_q) < n_eff)) else $error("pointer out of window");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(updated && gated)) else $error("updated and gated together");
	a_log_done: assert property (@(posedge clk) disable iff (!arst_n)
		log_done |-> (state_q == srag_pkg::ST_LOG_LVL || state_q == srag_pkg::ST_LS_WAIT
		|| state_q == srag_pkg::ST_LN_WAIT)) else $error("log result outside wait state");
`endif

endmodule

`default_nettype wire
